// File: hw/rtl/sdbp_pkg.sv
`timescale 1ns / 1ps

package sdbp_pkg;

    localparam int WEIGHT_W = 32;
    localparam int FIELD_W  = 5;

    // One row of the subset table: closed bins, fill of the open bin and the
    // index of the item that was added last.
    typedef struct packed {
        logic [FIELD_W-1:0]  closed;
        logic [WEIGHT_W-1:0] fill;
        logic [FIELD_W-1:0]  last;
    } t_entry;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_INIT,
        ST_SW_RD,
        ST_SW_DRAIN,
        ST_SW_WR,
        ST_BT_RD0,
        ST_BT_LOAD,
        ST_BT_ISSUE,
        ST_BT_TAKE,
        ST_EMIT
    } t_state;

endpackage

// File: hw/rtl/sdbp_ram.sv
`timescale 1ns / 1ps

module sdbp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: hw/rtl/subset_dp_bin_packing_unit.sv
`timescale 1ns / 1ps

// Channel    Dir  Handshake                 Payload
// s (input)  in   i_s_tvalid / o_s_tready   tdata[31:0] weight, tlast last_weight
// m (output) out  o_m_tvalid / i_m_tready   tdata[14:0] item_number, bin_index, bin_total;
//                                           tlast last_result
// cfg        in   i_cfg_wen                 i_cfg_wdata[31:0] capacity
//
// A weight word that does not end the set is taken while idle. The final
// word starts the subset sweep: the empty subset is seeded first, then each of
// the 2^n - 1 nonempty subsets is built in turn, reading the single table RAM
// port once per candidate item. Backtracking walks the table back item by item
// and the n result words follow at the pace of i_m_tready.
// Reset is synchronous and active low; it clears the control state and the
// capacity. The input is not ready from the final word until the last result
// word is taken; a stalled output simply holds its word.

module subset_dp_bin_packing_unit #(
    parameter int MAX_ITEMS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration: capacity of each bin.
    input  logic        i_cfg_wen,
    input  logic [31:0] i_cfg_wdata,
    // Input stream; tdata holds weight.
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [31:0] i_s_tdata,
    input  logic        i_s_tlast,
    // Output stream; tdata holds item_number [4:0], bin_index [9:5],
    // bin_total [14:10], and a zero pad bit [15].
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [15:0] o_m_tdata,
    output logic        o_m_tlast
);

    localparam int MASK_W = MAX_ITEMS;
    localparam int IDX_W  = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
    localparam int CNT_W  = $clog2(MAX_ITEMS + 1);
    localparam int FW     = sdbp_pkg::FIELD_W;
    localparam int WW     = sdbp_pkg::WEIGHT_W;

    // Control and datapath registers.
    sdbp_pkg::t_state r_state, n_state;
    logic [WW-1:0]     r_cap;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [CNT_W-1:0]  r_n, n_n;
    logic [MASK_W-1:0] r_mask, n_mask;
    logic [IDX_W-1:0]  r_i, n_i;
    logic              r_pv, n_pv;
    logic [IDX_W-1:0]  r_pidx, n_pidx;
    logic [WW-1:0]     r_pw, n_pw;
    logic              r_have, n_have;
    sdbp_pkg::t_entry  r_best, n_best;
    sdbp_pkg::t_entry  r_cur, n_cur;
    logic [CNT_W-1:0]  r_k, n_k;
    logic [FW-1:0]     r_bin, n_bin;
    logic [FW-1:0]     r_total, n_total;

    // Item weights and the backtracked packing.
    logic [WW-1:0] r_weights [MAX_ITEMS];
    logic [FW-1:0] r_buf_item [MAX_ITEMS];
    logic [FW-1:0] r_buf_bin [MAX_ITEMS];

    // Table RAM port signals.
    logic              ram_we;
    logic [MASK_W-1:0] ram_waddr;
    sdbp_pkg::t_entry  ram_wdata;
    logic [MASK_W-1:0] ram_raddr;
    sdbp_pkg::t_entry  ram_rdata;

    logic              s_acc;
    logic              m_acc;
    logic              wt_we;
    logic              buf_we;
    logic [MASK_W-1:0] full_mask;
    logic [MASK_W-1:0] bt_prev;
    logic [WW:0]       cand_sum;
    logic              cand_over;
    logic [FW-1:0]     cand_a;
    logic [WW-1:0]     cand_b;
    logic              cand_better;
    logic              step_closed;
    logic [FW-1:0]     step_bin;

    sdbp_ram #(
        .WIDTH ($bits(sdbp_pkg::t_entry)),
        .DEPTH (2 ** MAX_ITEMS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign o_s_tready = (r_state == sdbp_pkg::ST_IDLE);
    assign s_acc      = i_s_tvalid && o_s_tready;
    assign o_m_tvalid = (r_state == sdbp_pkg::ST_EMIT);
    assign m_acc      = o_m_tvalid && i_m_tready;
    assign o_m_tdata  = {1'b0, r_total, r_buf_bin[r_k[IDX_W-1:0]], r_buf_item[r_k[IDX_W-1:0]]};
    assign o_m_tlast  = (r_k == r_n - CNT_W'(1));

    // Mask with one bit for every loaded item.
    assign full_mask = MASK_W'(((MASK_W + 1)'(1) << r_n) - (MASK_W + 1)'(1));

    // Candidate for the current subset: add the pending item to the best
    // packing of the subset without it. An overflowing sum closes the open bin.
    assign cand_sum    = {1'b0, ram_rdata.fill} + {1'b0, r_pw};
    assign cand_over   = cand_sum > {1'b0, r_cap};
    assign cand_a      = ram_rdata.closed + FW'(cand_over);
    assign cand_b      = cand_over ? r_pw : cand_sum[WW-1:0];
    assign cand_better = !r_have || (cand_a < r_best.closed)
                         || ((cand_a == r_best.closed) && (cand_b < r_best.fill));

    // Backtracking step: a change in closed bins means the item opened its bin.
    assign bt_prev     = r_mask ^ (MASK_W'(1) << r_cur.last[IDX_W-1:0]);
    assign step_closed = (r_cur.closed != ram_rdata.closed);
    assign step_bin    = r_bin + FW'(step_closed);

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_n       = r_n;
        n_mask    = r_mask;
        n_i       = r_i;
        n_pv      = 1'b0;
        n_pidx    = r_pidx;
        n_pw      = r_pw;
        n_have    = r_have;
        n_best    = r_best;
        n_cur     = r_cur;
        n_k       = r_k;
        n_bin     = r_bin;
        n_total   = r_total;
        ram_we    = 1'b0;
        ram_waddr = r_mask;
        ram_wdata = r_best;
        ram_raddr = r_mask;
        wt_we     = 1'b0;
        buf_we    = 1'b0;

        case (r_state)
            sdbp_pkg::ST_IDLE: begin
                if (s_acc) begin
                    // Weights beyond the table size are dropped.
                    if (r_count < CNT_W'(MAX_ITEMS)) begin
                        wt_we   = 1'b1;
                        n_count = r_count + CNT_W'(1);
                    end
                    if (i_s_tlast) begin
                        n_n     = (r_count < CNT_W'(MAX_ITEMS)) ? r_count + CNT_W'(1) : r_count;
                        n_state = sdbp_pkg::ST_INIT;
                    end
                end
            end
            sdbp_pkg::ST_INIT: begin
                // The empty subset has no bins and no fill.
                ram_we    = 1'b1;
                ram_waddr = '0;
                ram_wdata = '0;
                n_mask    = MASK_W'(1);
                n_i       = '0;
                n_have    = 1'b0;
                n_state   = sdbp_pkg::ST_SW_RD;
            end
            sdbp_pkg::ST_SW_RD: begin
                ram_raddr = r_mask ^ (MASK_W'(1) << r_i);
                n_pv      = r_mask[r_i];
                n_pidx    = r_i;
                n_pw      = r_weights[r_i];
                if (r_pv && cand_better) begin
                    n_have = 1'b1;
                    n_best = '{closed: cand_a, fill: cand_b, last: FW'(r_pidx)};
                end
                if (CNT_W'(r_i) == r_n - CNT_W'(1)) begin
                    n_state = sdbp_pkg::ST_SW_DRAIN;
                end else begin
                    n_i = r_i + IDX_W'(1);
                end
            end
            sdbp_pkg::ST_SW_DRAIN: begin
                if (r_pv && cand_better) begin
                    n_have = 1'b1;
                    n_best = '{closed: cand_a, fill: cand_b, last: FW'(r_pidx)};
                end
                n_state = sdbp_pkg::ST_SW_WR;
            end
            sdbp_pkg::ST_SW_WR: begin
                ram_we = 1'b1;
                n_have = 1'b0;
                n_i    = '0;
                if (r_mask == full_mask) begin
                    n_state = sdbp_pkg::ST_BT_RD0;
                end else begin
                    n_mask  = r_mask + MASK_W'(1);
                    n_state = sdbp_pkg::ST_SW_RD;
                end
            end
            sdbp_pkg::ST_BT_RD0: begin
                n_k     = '0;
                n_bin   = '0;
                n_state = sdbp_pkg::ST_BT_LOAD;
            end
            sdbp_pkg::ST_BT_LOAD: begin
                n_cur   = ram_rdata;
                n_state = sdbp_pkg::ST_BT_ISSUE;
            end
            sdbp_pkg::ST_BT_ISSUE: begin
                ram_raddr = bt_prev;
                buf_we    = 1'b1;
                n_mask    = bt_prev;
                n_state   = sdbp_pkg::ST_BT_TAKE;
            end
            sdbp_pkg::ST_BT_TAKE: begin
                n_bin = step_bin;
                n_cur = ram_rdata;
                if (r_k + CNT_W'(1) == r_n) begin
                    // An empty bin left behind by the last step is not counted.
                    n_total = step_closed ? step_bin : step_bin + FW'(1);
                    n_k     = '0;
                    n_state = sdbp_pkg::ST_EMIT;
                end else begin
                    n_k     = r_k + CNT_W'(1);
                    n_state = sdbp_pkg::ST_BT_ISSUE;
                end
            end
            sdbp_pkg::ST_EMIT: begin
                if (m_acc) begin
                    if (o_m_tlast) begin
                        n_count = '0;
                        n_state = sdbp_pkg::ST_IDLE;
                    end else begin
                        n_k = r_k + CNT_W'(1);
                    end
                end
            end
            default: begin
                n_state = sdbp_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sdbp_pkg::ST_IDLE;
            r_cap   <= '0;
            r_count <= '0;
            r_pv    <= 1'b0;
            r_have  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_pv    <= n_pv;
            r_have  <= n_have;
            if (i_cfg_wen) begin
                r_cap <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_n     <= n_n;
        r_mask  <= n_mask;
        r_i     <= n_i;
        r_pidx  <= n_pidx;
        r_pw    <= n_pw;
        r_best  <= n_best;
        r_cur   <= n_cur;
        r_k     <= n_k;
        r_bin   <= n_bin;
        r_total <= n_total;
        if (wt_we) begin
            r_weights[r_count[IDX_W-1:0]] <= i_s_tdata;
        end
        if (buf_we) begin
            r_buf_item[r_k[IDX_W-1:0]] <= r_cur.last + FW'(1);
            r_buf_bin[r_k[IDX_W-1:0]]  <= r_bin;
        end
    end

endmodule
